### sv/erpm_pkg.sv
package erpm_pkg;

    // field and datapath widths
    localparam int GAIN_W   = 16;
    localparam int RPM_W    = 16;
    localparam int DUTY_W   = 7;
    localparam int CNT_W    = 4;
    localparam int TIME_W   = 32;
    localparam int TGT_W    = 16;
    localparam int ERR_W    = 18;
    localparam int PROD_W   = GAIN_W + 1 + ERR_W;
    localparam int DVD_W    = 36;
    localparam int DVS_W    = 32;

    localparam int AVG_COUNT_DEF = 10;

    // 1e9 ns * 60 / 12 / 25 / 50 folds into 4e6 / mean_period
    localparam logic [DVD_W-1:0]  RPM_NUM   = DVD_W'(4000000);
    localparam logic [DUTY_W-1:0] DUTY_MAX  = DUTY_W'(100);
    localparam logic [GAIN_W-1:0] PROP_RST  = GAIN_W'(384);
    localparam logic [GAIN_W-1:0] INTEG_RST = GAIN_W'(20);

    // register index, taken from paddr[2]
    localparam logic REG_PROP  = 1'b0;
    localparam logic REG_INTEG = 1'b1;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_CTRL  = 2'd1,
        OP_STALL = 2'd2
    } t_op;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

### sv/erpm_div.sv
module erpm_div
    import erpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_ctl i_ctl,
    output t_div_rsp o_rsp
);

    localparam int CntW = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CntW-1:0]  r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             fits;

    // restoring step: one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign fits     = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_ctl.start && r_busy && (r_cnt == CntW'(DVD_W - 1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_ctl.dividend;
                r_rem  <= '0;
                r_dvs  <= i_ctl.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### sv/erpm_mul.sv
module erpm_mul
    import erpm_pkg::*;
(
    input  logic                     i_clk,
    input  logic [GAIN_W-1:0]        i_a,
    input  logic signed [ERR_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // unsigned gain times signed operand, registered
    always_ff @(posedge i_clk) begin
        r_prod <= signed'({1'b0, i_a}) * i_b;
    end

    assign o_prod = r_prod;

endmodule

### sv/encoder_rpm_pi_speed_control_core.sv
// an edge that closes the window works out the mean in 9 radix-16 steps, then the rpm in a
//   36-step division; a zero mean skips the division
// one transaction in flight at a time, taken again in the cycle after the result is loaded;
//   the 17x18 multiplier is shared by the products of the control path
// reset: synchronous active low; gains return to 1.5 and about 0.08, speed state clears,
//   direction goes forward, no result pending
module encoder_rpm_pi_speed_control_core
    import erpm_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // capture_time [31:0], target_rpm [47:32]
    input  logic [1:0]  s_axis_tuser,   // operation [1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // duty_percent [6:0], forward [7], measured_rpm [23:8]
    output logic        m_axis_tuser,   // duty_updated [0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_E_PER,
        S_E_SUM,
        S_E_MEAN,
        S_E_RPM,
        S_C_ERR,
        S_C_MUL1,
        S_C_ACC,
        S_C_SUM,
        S_C_MUL2,
        S_C_MUL3,
        S_C_COMB,
        S_C_RND,
        S_C_DEC,
        S_STALL,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [GAIN_W-1:0] r_prop;
    logic [GAIN_W-1:0] r_integ_gain;

    // latched transaction payload
    logic [TIME_W-1:0]       r_cap;
    logic signed [TGT_W-1:0] r_target;
    logic                    r_upd;

    // speed measurement state
    logic [TIME_W-1:0] r_prev_cap;
    logic [DVD_W-1:0]  r_win_sum;
    logic [CNT_W-1:0]  r_edge_cnt;
    logic [DVS_W-1:0]  r_mean;
    logic [DVS_W-1:0]  r_stall_ref;
    logic [RPM_W-1:0]  r_rpm;

    // controller state
    logic signed [31:0] r_integral;
    logic [DUTY_W-1:0]  r_duty;
    logic               r_fwd;

    // working registers of the sequencer
    logic [TIME_W-1:0]        r_period;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [31:0]       r_integ_new;
    logic signed [32:0]       r_sum;
    logic signed [49:0]       r_acc;
    logic signed [33:0]       r_req;

    // window mean, one radix-16 digit per cycle
    logic [DVD_W-1:0]         r_mq_num;
    logic [3:0]               r_mq_rem;
    logic [DVS_W-1:0]         r_mq_quo;
    logic [3:0]               r_mq_cnt;

    // result register
    logic                     r_m_valid;
    logic [23:0]              r_m_data;
    logic                     r_m_user;

    // divider and shared multiplier
    t_div_ctl                 r_div_ctl;
    t_div_rsp                 div_rsp;
    logic [GAIN_W-1:0]        mul_a;
    logic signed [ERR_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    // combinational helpers
    logic signed [16:0]       tgt_ext;
    logic [16:0]              tgt_mag;
    logic [DVD_W-1:0]         sum_next;
    logic [CNT_W-1:0]         cnt_next;
    logic signed [35:0]       integ_sum;
    logic signed [31:0]       integ_sat;
    logic signed [32:0]       err_sh;
    logic signed [49:0]       acc_adj;
    logic [7:0]               mq_val;
    logic [3:0]               mq_digit;
    logic [7:0]               mq_sub;
    logic                     mq_last;
    logic [DVS_W-1:0]         mean_q;
    logic                     cfg_wr;

    //--------------------------------------------------------------------
    // configuration port, written in the access phase
    //--------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop       <= PROP_RST;
            r_integ_gain <= INTEG_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PROP:  r_prop       <= pwdata[GAIN_W-1:0];
                REG_INTEG: r_integ_gain <= pwdata[GAIN_W-1:0];
                default:   r_prop       <= r_prop;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_INTEG) ? {16'h0000, r_integ_gain} : {16'h0000, r_prop};

    //--------------------------------------------------------------------
    // shared by no other path: the divider gives the rpm from the mean period
    //--------------------------------------------------------------------
    erpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_div_ctl),
        .o_rsp   (div_rsp)
    );

    //--------------------------------------------------------------------
    // shared multiplier: integral term, then the two halves of the P term
    //--------------------------------------------------------------------
    always_comb begin
        case (r_state)
            S_C_MUL1: begin
                mul_a = r_integ_gain;
                mul_b = r_err;
            end
            S_C_MUL2: begin
                // low half of the PI sum, never negative
                mul_a = r_prop;
                mul_b = signed'({2'b00, r_sum[15:0]});
            end
            default: begin
                // high half of the PI sum, signed, weight 2^16
                mul_a = r_prop;
                mul_b = signed'({r_sum[32], r_sum[32:16]});
            end
        endcase
    end

    erpm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    //--------------------------------------------------------------------
    // datapath helpers
    //--------------------------------------------------------------------
    // target magnitude, -32768 gives 32768
    assign tgt_ext  = 17'(r_target);
    assign tgt_mag  = tgt_ext[16] ? 17'(-tgt_ext) : 17'(tgt_ext);

    assign sum_next = r_win_sum + DVD_W'(r_period);
    assign cnt_next = r_edge_cnt + 1'b1;

    // integral update, saturated to signed 32 bits
    assign integ_sum = 36'(r_integral) + 36'(mul_prod);
    always_comb begin
        if (integ_sum[35:31] == 5'b00000 || integ_sum[35:31] == 5'b11111) begin
            integ_sat = integ_sum[31:0];
        end else if (integ_sum[35]) begin
            integ_sat = 32'sh8000_0000;
        end else begin
            integ_sat = 32'sh7FFF_FFFF;
        end
    end

    assign err_sh  = 33'(signed'({r_err, 8'h00}));
    // bias negative products so the shift truncates toward zero
    assign acc_adj = r_acc + (r_acc[49] ? 50'sd65535 : 50'sd0);

    // window sum over AVG_COUNT: remainder stays below the count, so each digit fits 4 bits,
    // digit picked by comparing against the constant multiples of the count
    assign mq_val = {r_mq_rem, r_mq_num[DVD_W-1 -: 4]};
    always_comb begin
        mq_digit = '0;
        mq_sub   = '0;
        for (int k = 1; k < 16; k++) begin
            if (mq_val >= 8'(k * AVG_COUNT)) begin
                mq_digit = 4'(k);
                mq_sub   = 8'(k * AVG_COUNT);
            end
        end
    end

    // mean keeps the low 32 bits of the quotient
    assign mean_q  = {r_mq_quo[DVS_W-5:0], mq_digit};
    assign mq_last = (r_mq_cnt == 4'(DVD_W / 4 - 1));

    //--------------------------------------------------------------------
    // sequencer
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_div_ctl.start <= 1'b0;
            r_m_valid       <= 1'b0;
            r_prev_cap      <= '0;
            r_win_sum       <= '0;
            r_edge_cnt      <= '0;
            r_mean          <= '0;
            r_stall_ref     <= '0;
            r_rpm           <= '0;
            r_integral      <= '0;
            r_duty          <= '0;
            r_fwd           <= 1'b1;
        end else begin
            // rpm division starts once the last mean digit is in and the mean is nonzero
            r_div_ctl.start <= (r_state == S_E_MEAN) && mq_last && (mean_q != '0);

            if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cap    <= s_axis_tdata[31:0];
                        r_target <= s_axis_tdata[47:32];
                        r_upd    <= (s_axis_tuser == OP_CTRL);
                        case (t_op'(s_axis_tuser))
                            OP_EDGE:  r_state <= S_E_PER;
                            OP_CTRL:  r_state <= S_C_ERR;
                            OP_STALL: r_state <= S_STALL;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end

                // edge: period since last capture, timer wraps
                S_E_PER: begin
                    r_period   <= r_cap - r_prev_cap;
                    r_prev_cap <= r_cap;
                    r_state    <= S_E_SUM;
                end

                S_E_SUM: begin
                    if (cnt_next == CNT_W'(AVG_COUNT)) begin
                        // window closes: start a fresh one and work out the mean
                        r_win_sum  <= '0;
                        r_edge_cnt <= '0;
                        r_mq_num   <= sum_next;
                        r_mq_rem   <= '0;
                        r_mq_cnt   <= '0;
                        r_state    <= S_E_MEAN;
                    end else begin
                        r_win_sum  <= sum_next;
                        r_edge_cnt <= cnt_next;
                        r_state    <= S_DONE;
                    end
                end

                S_E_MEAN: begin
                    r_mq_rem <= 4'(mq_val - mq_sub);
                    r_mq_quo <= mean_q;
                    r_mq_num <= {r_mq_num[DVD_W-5:0], 4'h0};
                    r_mq_cnt <= r_mq_cnt + 1'b1;
                    if (mq_last) begin
                        r_mean <= mean_q;
                        if (mean_q == '0) begin
                            r_rpm   <= '1;
                            r_state <= S_DONE;
                        end else begin
                            r_div_ctl.dividend <= RPM_NUM;
                            r_div_ctl.divisor  <= mean_q;
                            r_state            <= S_E_RPM;
                        end
                    end
                end

                S_E_RPM: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient[DVD_W-1:RPM_W] != '0) begin
                            r_rpm <= '1;
                        end else begin
                            r_rpm <= div_rsp.quotient[RPM_W-1:0];
                        end
                        r_state <= S_DONE;
                    end
                end

                // control: error from target magnitude, sign sets direction
                S_C_ERR: begin
                    r_err   <= signed'({1'b0, tgt_mag}) - signed'({2'b00, r_rpm});
                    r_fwd   <= ~r_target[TGT_W-1];
                    r_state <= S_C_MUL1;
                end

                S_C_MUL1: begin
                    r_state <= S_C_ACC;
                end

                S_C_ACC: begin
                    r_integ_new <= integ_sat;
                    r_state     <= S_C_SUM;
                end

                S_C_SUM: begin
                    r_sum   <= err_sh + 33'(r_integ_new);
                    r_state <= S_C_MUL2;
                end

                S_C_MUL2: begin
                    r_state <= S_C_MUL3;
                end

                S_C_MUL3: begin
                    r_acc   <= 50'(mul_prod);
                    r_state <= S_C_COMB;
                end

                S_C_COMB: begin
                    r_acc   <= (50'(mul_prod) <<< 16) + r_acc;
                    r_state <= S_C_RND;
                end

                S_C_RND: begin
                    r_req   <= acc_adj[49:16];
                    r_state <= S_C_DEC;
                end

                // clamp, undo the integral step when pushing further into saturation
                S_C_DEC: begin
                    if (r_req > 34'sd100 && !r_err[ERR_W-1] && r_err != '0) begin
                        r_duty <= DUTY_MAX;
                    end else if (r_req[33] && r_err[ERR_W-1]) begin
                        r_duty <= '0;
                    end else if (r_req > 34'sd100) begin
                        r_duty     <= DUTY_MAX;
                        r_integral <= r_integ_new;
                    end else if (r_req[33]) begin
                        r_duty     <= '0;
                        r_integral <= r_integ_new;
                    end else begin
                        r_duty     <= r_req[DUTY_W-1:0];
                        r_integral <= r_integ_new;
                    end
                    r_state <= S_DONE;
                end

                // stall: mean unchanged since the last tick means no motion
                S_STALL: begin
                    if (r_stall_ref == r_mean) begin
                        r_rpm <= '0;
                    end
                    r_stall_ref <= r_mean;
                    r_state     <= S_DONE;
                end

                // hand the result over once the output register is free
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= {r_rpm, r_fwd, r_duty};
                        r_m_user  <= r_upd;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // one transaction in flight at a time
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

### sv/erpm_chk.sv
module erpm_chk
    import erpm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // one transaction at a time: input closes right after an accept
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("input still open after a transaction was taken");

    // duty never leaves 0..100
    a_duty_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= DUTY_MAX)
    ) else $error("duty out of range");

    // a result is never produced without an earlier input transaction in flight
    a_no_result_while_idle_open: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($rose(m_axis_tvalid) && $past(i_rst_n)) |-> $past(!s_axis_tready)
    ) else $error("result appeared with no transaction in progress");

    // stalled result holds
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    ) else $error("stalled result changed");

endmodule

bind encoder_rpm_pi_speed_control_core erpm_chk u_erpm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### sim/erpm_speed_checker.sv
`timescale 1ns / 1ps

module erpm_speed_checker
    import erpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_in_data,    // capture_time [31:0], target_rpm [47:32]
    input  logic [1:0]  i_in_user,    // operation [1:0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,   // duty_percent [6:0], forward [7], measured_rpm [23:8]
    input  logic        i_out_user,   // duty_updated [0]
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_error_count,
    output int          o_pending
);

    localparam int                AVG_EDGES  = AVG_COUNT_DEF;
    localparam longint unsigned   NS_PER_SEC = 64'd1000000000;
    localparam longint            I32_MAX    = 64'sd2147483647;
    localparam longint            I32_MIN    = -64'sd2147483648;
    localparam longint            DUTY_TOP   = 100;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              forward;
        logic [RPM_W-1:0]  rpm;
        logic              updated;
    } t_speed_result;

    t_speed_result expected_results[$];

    // own copy of the gains and the speed loop state
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [TIME_W-1:0]        last_capture;
    logic [35:0]              period_sum;
    logic [CNT_W-1:0]         edge_count;
    logic [31:0]              mean_period;
    logic [31:0]              stall_ref;
    logic [RPM_W-1:0]         speed;
    logic signed [31:0]       integ_acc;
    logic [DUTY_W-1:0]        duty_now;
    logic                     dir_fwd;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    function automatic logic [RPM_W-1:0] rpm_from_period(logic [31:0] mean);
        longint unsigned q;
        longint unsigned r;
        if (mean == 32'd0)
            return '1;
        q = NS_PER_SEC / {32'd0, mean};
        r = (((q * 60) / 12) / 25) / 50;
        return (r > 64'd65535) ? '1 : r[RPM_W-1:0];
    endfunction

    function automatic t_speed_result advance_speed_model(logic [1:0] op,
                                                          logic [TIME_W-1:0] capture,
                                                          logic [TGT_W-1:0] target);
        logic [TIME_W-1:0]  period;
        longint             tgt;
        longint             rpm_l;
        longint             pg;
        longint             ig;
        longint             err;
        longint             acc;
        longint             sum;
        longint             req;
        logic signed [31:0] saved;
        t_speed_result      res;
        res.updated = 1'b0;
        case (op)
            OP_EDGE: begin
                period       = capture - last_capture;
                period_sum   = period_sum + {4'd0, period};
                edge_count   = edge_count + 1'b1;
                if (edge_count >= AVG_EDGES) begin
                    mean_period = 32'(period_sum / 36'(AVG_EDGES));
                    period_sum  = '0;
                    edge_count  = '0;
                    speed       = rpm_from_period(mean_period);
                end
                last_capture = capture;
            end
            OP_CTRL: begin
                tgt   = $signed(target);
                rpm_l = speed;
                pg    = prop_gain;
                ig    = integ_gain;
                saved = integ_acc;
                if (tgt >= 0) begin
                    err     = tgt - rpm_l;
                    dir_fwd = 1'b1;
                end else begin
                    err     = -tgt - rpm_l;
                    dir_fwd = 1'b0;
                end
                acc = integ_acc;
                acc = acc + ig * err;
                if (acc > I32_MAX)
                    acc = I32_MAX;
                if (acc < I32_MIN)
                    acc = I32_MIN;
                integ_acc = acc[31:0];
                sum = err * 256 + longint'(integ_acc);
                req = (pg * sum) / 65536;
                // undo the integration when it only pushes further into the clamp
                if (req > DUTY_TOP && err > 0) begin
                    integ_acc = saved;
                    duty_now  = DUTY_MAX;
                end else if (req < 0 && err < 0) begin
                    integ_acc = saved;
                    duty_now  = '0;
                end else if (req > DUTY_TOP) begin
                    duty_now = DUTY_MAX;
                end else if (req < 0) begin
                    duty_now = '0;
                end else begin
                    duty_now = req[DUTY_W-1:0];
                end
                res.updated = 1'b1;
            end
            OP_STALL: begin
                if (stall_ref == mean_period)
                    speed = '0;
                stall_ref = mean_period;
            end
            default: ;
        endcase
        res.duty    = duty_now;
        res.forward = dir_fwd;
        res.rpm     = speed;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_speed_result want;
        t_speed_result got;
        if (!i_rst_n) begin
            prop_gain    = PROP_RST;
            integ_gain   = INTEG_RST;
            last_capture = '0;
            period_sum   = '0;
            edge_count   = '0;
            mean_period  = '0;
            stall_ref    = '0;
            speed        = '0;
            integ_acc    = '0;
            duty_now     = '0;
            dir_fwd      = 1'b1;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_INTEG)
                    integ_gain = i_pwdata[GAIN_W-1:0];
                else
                    prop_gain = i_pwdata[GAIN_W-1:0];
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(advance_speed_model(i_in_user,
                                                               i_in_data[31:0],
                                                               i_in_data[47:32]));
            if (i_out_valid && i_out_ready) begin
                got.duty    = i_out_data[6:0];
                got.forward = i_out_data[7];
                got.rpm     = i_out_data[23:8];
                got.updated = i_out_user;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: duty %0d fwd %0d rpm %0d upd %0d",
                             $time, got.duty, got.forward, got.rpm, got.updated);
                    o_error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.duty !== want.duty) begin
                        $display("%0t: duty_percent expected %0d got %0d",
                                 $time, want.duty, got.duty);
                        o_error_count++;
                    end
                    if (got.forward !== want.forward) begin
                        $display("%0t: forward expected %0d got %0d",
                                 $time, want.forward, got.forward);
                        o_error_count++;
                    end
                    if (got.rpm !== want.rpm) begin
                        $display("%0t: measured_rpm expected %0d got %0d",
                                 $time, want.rpm, got.rpm);
                        o_error_count++;
                    end
                    if (got.updated !== want.updated) begin
                        $display("%0t: duty_updated expected %0d got %0d",
                                 $time, want.updated, got.updated);
                        o_error_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### sim/tb_encoder_rpm_pi_speed_control_core.sv
`timescale 1ns / 1ps

module tb_encoder_rpm_pi_speed_control_core;
    import erpm_pkg::*;

    // operation code the block must pass through untouched
    localparam logic [1:0] OP_SPARE        = 2'd3;
    localparam int         NUM_PHASES      = 7;
    localparam int         ITEMS_PER_PHASE = 100;
    // a window-closing edge is the slowest transaction, so wait well beyond it
    localparam int         SETTLE_CYCLES   = 120;
    // long receiver hold-off so the block backs up into its input
    localparam int         HOLD_CYCLES     = 400;
    localparam int         PRESSURE_PHASE  = 5;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;     // capture_time [31:0], target_rpm [47:32]
    logic [1:0]  s_tuser  = '0;     // operation [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // duty_percent [6:0], forward [7], measured_rpm [23:8]
    logic        m_tuser;           // duty_updated [0]

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          pending;

    // idle percentages of both sides, changed per phase
    int          send_idle_pct = 17;
    int          recv_idle_pct = 63;
    bit          hold_req      = 1'b0;

    // running encoder timer, wraps like the real one
    logic [31:0] cap_now = '0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    encoder_rpm_pi_speed_control_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    erpm_speed_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_data     (s_tdata),
        .i_in_user     (s_tuser),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_data    (m_tdata),
        .i_out_user    (m_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // offer one transaction, with a random gap first, and wait until it is taken
    task automatic send_item(input logic [1:0] op, input logic [31:0] capture,
                             input logic [15:0] target);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {target, capture};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // stop offering, let every expected result come out and the block go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write: setup cycle then access cycle, then the bus returns to idle
    task automatic reg_write(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // encoder edge spaced by a period of a random speed class
    task automatic send_edge();
        int          k;
        logic [31:0] period;
        k = $urandom_range(0, 99);
        if (k < 8)
            period = $urandom_range(0, 600);            // very fast, rpm saturates only for the shortest periods
        else if (k < 85)
            period = $urandom_range(800, 200000);       // normal running speeds
        else if (k < 95)
            period = $urandom_range(200000, 40000000);  // crawling
        else
            period = $urandom;                          // anything, wrap included
        // now and then a timestamp out of sequence
        if ($urandom_range(0, 49) == 0)
            cap_now = $urandom;
        else
            cap_now = cap_now + period;
        send_item(OP_EDGE, cap_now, 16'($urandom));
    endtask

    task automatic send_random_item();
        int          pick;
        int          k;
        logic [15:0] tgt;
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            send_edge();
        end else if (pick < 83) begin
            k = $urandom_range(0, 99);
            if (k < 60)
                tgt = 16'($urandom_range(0, 4000));
            else if (k < 85)
                tgt = 16'($urandom_range(0, 32767));
            else
                tgt = 16'($urandom);
            if (k < 85 && $urandom_range(0, 1) == 1)
                tgt = -tgt;
            send_item(OP_CTRL, $urandom, tgt);
        end else if (pick < 97) begin
            send_item(OP_STALL, $urandom, 16'($urandom));
        end else begin
            send_item(OP_SPARE, $urandom, 16'($urandom));
        end
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin : recv_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        logic [15:0] pg;
        logic [15:0] ig;
        int          mode;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset gains
        send_item(OP_STALL, 32'd0, 16'd0);          // first stall: reference equals mean
        send_item(OP_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_CTRL, 32'd0, 16'd0);
        send_item(OP_CTRL, 32'hFFFF_FFFF, 16'h7FFF);  // largest forward target, clamp at top
        send_item(OP_CTRL, 32'd0, 16'h8000);          // most negative target
        send_item(OP_CTRL, 32'd0, 16'hFFFF);          // minus one, reverse
        // a window of zero periods: mean of zero saturates the rpm
        repeat (AVG_COUNT_DEF) send_item(OP_EDGE, 32'd0, 16'd0);
        send_item(OP_CTRL, 32'd0, 16'd0);             // big negative error, clamp at zero
        send_item(OP_STALL, 32'd0, 16'd0);
        send_item(OP_STALL, 32'd0, 16'd0);            // mean unchanged, rpm stays at zero
        send_item(OP_EDGE, 32'hFFFF_FFFF, 16'd0);
        send_item(OP_EDGE, 32'd0, 16'd0);             // timer wrap, period of one
        send_item(OP_CTRL, 32'd0, 16'd100);
        send_item(OP_STALL, 32'd0, 16'd0);
        send_item(OP_SPARE, 32'd0, 16'd0);
        cap_now = '0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0: begin pg = PROP_RST; ig = INTEG_RST; end
                1: begin pg = 16'd0;    ig = 16'd0;     end
                2: begin pg = 16'hFFFF; ig = 16'hFFFF;  end
                3: begin pg = 16'd256;  ig = 16'd1;     end
                4: begin pg = 16'($urandom); ig = 16'($urandom); end
                5: begin pg = 16'd1;    ig = 16'hFFFF;  end
                default: begin pg = 16'hFFFF; ig = 16'd0; end
            endcase
            reg_write(REG_PROP, pg);
            reg_write(REG_INTEG, ig);

            // receiver lazy first, then sender lazy, then both eager
            mode = (p * 3) / NUM_PHASES;
            if (mode == 0) begin
                send_idle_pct = 17;
                recv_idle_pct = 63;
            end else if (mode == 1) begin
                send_idle_pct = 63;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == PRESSURE_PHASE && i == 20)
                    hold_req = 1'b1;
                send_random_item();
            end
        end

        drain();
        if (error_count == 0)
            $display("tb_encoder_rpm_pi_speed_control_core: clean");
        else
            $display("tb_encoder_rpm_pi_speed_control_core: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("tb_encoder_rpm_pi_speed_control_core: errors");
        $finish;
    end

endmodule
